### hw/rtl/sis_pkg.sv
`timescale 1ns / 1ps

package sis_pkg;

  // Number of values the store can hold.
  localparam int CAP = 32;

  // Width of the internal fill count, wide enough to hold CAP itself.
  localparam int CNT_W = $clog2(CAP + 1);

  // Width of an index into the row of cells.
  localparam int IDX_W = $clog2(CAP);

  // Widths of the item fields.
  localparam int VAL_W = 32;
  localparam int OUT_CNT_W = 6;
  localparam int STATUS_W = 2;

  // Opcodes of an input item.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ITEM = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // Controller states.
  typedef enum logic {
    SIS_IDLE,
    SIS_READ
  } sis_state_e;

  // Commands from the controller to the row of cells.
  typedef struct packed {
    logic ins;  // insert the value in sorted position
    logic rot;  // rotate the occupied cells up by one place
  } sis_ctrl_t;

endpackage

### hw/rtl/sorted_insert_store.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   opcode_i, value_i
// result    out        out_valid_o / out_stall_i status_o, value_res_o, count_o, last_o
//
// On an insert, every cell compares against the new value at once and the row
// shifts by one place; its single result is registered.
// A read of n values first takes the item, then gives one result per cycle while
// the output is not stalled, as the cell row rotates through the read tap; input
// is held off until the last one is loaded.
// Reset empties the store by clearing the fill count; cell contents need none.
// A stalled result holds the output register; a new item is taken once it drains.

module sorted_insert_store
  import sis_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [VAL_W-1:0]     value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [VAL_W-1:0]     value_res_o,
  output logic [OUT_CNT_W-1:0] count_o,
  output logic                 last_o
);

  sis_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic             out_valid_q, out_valid_d;

  logic [STATUS_W-1:0] status_q, status_d;
  logic [VAL_W-1:0]    res_q, res_d;
  logic [CNT_W-1:0]    rcnt_q, rcnt_d;
  logic                last_q, last_d;

  logic             out_free;
  logic             in_acc;
  logic             full;
  logic             load;
  sis_ctrl_t        ctrl;
  logic [VAL_W-1:0] top_val;

  // Handshake.
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != SIS_IDLE) || !out_free;
  assign in_acc = in_valid_i && !in_stall_o;
  assign full = (cnt_q == CNT_W'(CAP));

  // Row of compare-and-shift cells.
  sis_chain u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .count_i   (cnt_q),
    .ins_val_i (value_i),
    .top_val_o (top_val)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIS_IDLE: begin
        if (in_acc && opcode_i == OP_READ && cnt_q != '0) begin
          state_d = SIS_READ;
        end
      end
      SIS_READ: begin
        if (out_free && left_q == CNT_W'(1)) begin
          state_d = SIS_IDLE;
        end
      end
      default: state_d = SIS_IDLE;
    endcase
  end

  // Controller outputs and result formation.
  always_comb begin
    ctrl = '0;
    load = 1'b0;
    cnt_d = cnt_q;
    left_d = left_q;
    status_d = status_q;
    res_d = res_q;
    rcnt_d = rcnt_q;
    last_d = last_q;
    case (state_q)
      SIS_IDLE: begin
        if (in_acc) begin
          load = 1'b1;
          res_d = '0;
          last_d = 1'b1;
          if (opcode_i == OP_INSERT) begin
            if (full) begin
              status_d = ST_FULL;
              rcnt_d = cnt_q;
            end else begin
              ctrl.ins = 1'b1;
              cnt_d = cnt_q + CNT_W'(1);
              status_d = ST_INSERTED;
              rcnt_d = cnt_q + CNT_W'(1);
            end
          end else if (cnt_q == '0) begin
            status_d = ST_EMPTY;
            rcnt_d = '0;
          end else begin
            // The values follow from the read state, one per cycle while the output is not stalled.
            load = 1'b0;
            left_d = cnt_q;
          end
        end
      end
      SIS_READ: begin
        if (out_free) begin
          ctrl.rot = 1'b1;
          load = 1'b1;
          status_d = ST_ITEM;
          res_d = top_val;
          rcnt_d = cnt_q;
          last_d = (left_q == CNT_W'(1));
          left_d = left_q - CNT_W'(1);
        end
      end
      default: begin
        ctrl = '0;
      end
    endcase
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIS_IDLE;
      cnt_q <= '0;
      left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      left_q <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      res_q <= res_d;
      rcnt_q <= rcnt_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign value_res_o = res_q;
  assign count_o = rcnt_q[OUT_CNT_W-1:0];
  assign last_o = last_q;

  // The fill count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAP))
    else $error("fill count exceeds capacity");

  // A read in progress always has values left to send and a nonempty store.
  a_read_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SIS_READ |-> (left_q != '0 && cnt_q != '0))
    else $error("read state with nothing left to send");

  // An insert grows the store by exactly one.
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("insert did not grow the store by one");

  // No new item is taken while a read is still streaming.
  a_no_accept_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SIS_READ |-> !in_acc)
    else $error("item accepted during a read");

endmodule

### hw/rtl/sis_cell.sv
`timescale 1ns / 1ps

module sis_cell
  import sis_pkg::*;
(
  input  logic             clk_i,
  input  sis_ctrl_t        ctrl_i,
  input  logic             occ_i,
  input  logic             prev_lt_i,
  input  logic [VAL_W-1:0] prev_val_i,
  input  logic [VAL_W-1:0] ins_val_i,
  output logic             lt_o,
  output logic [VAL_W-1:0] val_o
);

  logic [VAL_W-1:0] val_q;
  logic [VAL_W-1:0] val_d;

  // The stored value stays in place when it is less than the new value.
  assign lt_o = occ_i && ($signed(val_q) < $signed(ins_val_i));
  assign val_o = val_q;

  // On insert, the first cell that is not less takes the new value and every
  // cell after it takes its left neighbor. On rotate, every cell shifts up.
  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (!lt_o) begin
        val_d = prev_lt_i ? ins_val_i : prev_val_i;
      end
    end else if (ctrl_i.rot) begin
      val_d = prev_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

### hw/rtl/sis_chain.sv
`timescale 1ns / 1ps

module sis_chain
  import sis_pkg::*;
(
  input  logic             clk_i,
  input  sis_ctrl_t        ctrl_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [VAL_W-1:0] ins_val_i,
  output logic [VAL_W-1:0] top_val_o
);

  logic [CAP-1:0]            occ;
  logic [CAP-1:0]            lt;
  logic [CAP-1:0][VAL_W-1:0] vals;
  logic [IDX_W-1:0]          top_idx;

  // The highest occupied cell holds the largest value. It is the read tap and
  // feeds cell zero, so a rotation stays within the occupied cells.
  assign top_idx = IDX_W'(count_i - CNT_W'(1));
  assign top_val_o = vals[top_idx];

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    assign occ[g] = (CNT_W'(g) < count_i);

    if (g == 0) begin : g_first
      sis_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl_i),
        .occ_i      (occ[g]),
        .prev_lt_i  (1'b1),
        .prev_val_i (top_val_o),
        .ins_val_i  (ins_val_i),
        .lt_o       (lt[g]),
        .val_o      (vals[g])
      );
    end else begin : g_rest
      sis_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl_i),
        .occ_i      (occ[g]),
        .prev_lt_i  (lt[g-1]),
        .prev_val_i (vals[g-1]),
        .ins_val_i  (ins_val_i),
        .lt_o       (lt[g]),
        .val_o      (vals[g])
      );
    end
  end

endmodule
